// File: sv/run_free_list_slot_allocator_top_defines.svh
// Assertion macros shared by the slot allocator checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef RUN_FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define RUN_FREE_LIST_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rfl_pkg.sv
// Shared sizes, opcodes and beat layouts of the run free list slot allocator.
// No dependencies.
package rfl_pkg;

  localparam int MAX_BLOCKS          = 16;
  localparam int SLOTS_PER_BLOCK_MAX = 64;
  localparam int TABLE_DEPTH         = MAX_BLOCKS * SLOTS_PER_BLOCK_MAX;

  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int LINK_W = SLOT_W + 1;
  localparam int OFF_W  = $clog2(SLOTS_PER_BLOCK_MAX);
  localparam int BLK_W  = SLOT_W - OFF_W;
  localparam int OPEN_W = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W  = 7;
  localparam int APB_W  = 7;
  localparam int SIZE_W = 13;
  localparam int ADDR_W = 22;
  localparam int OP_W   = 2;

  localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(TABLE_DEPTH);

  // Configuration register indexes.
  localparam logic REG_APB       = 1'b0;
  localparam logic REG_ATOM_SIZE = 1'b1;

  // Input beat: op, slot_in.
  localparam int IN_DATA_W  = 16;
  // Output beat: status, slot_out, byte_address.
  localparam int OUT_STAT_LSB = 0;
  localparam int OUT_SLOT_LSB = 1;
  localparam int OUT_ADDR_LSB = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_USED_W   = OUT_ADDR_LSB + ADDR_W;
  localparam int OUT_DATA_W   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

  // One free-list node: link to the next run head and the run's slot count.
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [LEN_W-1:0]  len;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // Register value clamped to the legal slots-per-block range.
  function automatic logic [APB_W-1:0] eff_apb(input logic [APB_W-1:0] a);
    logic [APB_W-1:0] r;
    r = a;
    if (a == '0) r = APB_W'(1);
    else if (a > APB_W'(SLOTS_PER_BLOCK_MAX)) r = APB_W'(SLOTS_PER_BLOCK_MAX);
    return r;
  endfunction

endpackage

// File: sv/rfl_node_ram.sv
// Simple dual-port synchronous RAM holding the free-list nodes.
// One write and one read port, registered read data. No dependencies.
module rfl_node_ram #(
  parameter int AW = 10,
  parameter int DW = 18
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/run_free_list_slot_allocator_top.sv
// Run free list slot allocator. Every beat on the input gives exactly one result beat.
// A free, an allocation that opens a new block, a failed allocation and an unknown op
// are handled in the cycle the beat is taken; an allocation from the list passes through
// S_RMW, because the head node is read from the node RAM (registered read data)
// and written back in the next cycle. Empty queues its result at once but holds the
// input after the beat is taken while it rewrites the open block heads, one block
// head per cycle through the single RAM write port. A result then passes two
// registers on its way to out_tdata: the result register, and the output register
// that also captures slot times atom_size. Node RAM contents are undefined after
// reset; only written run heads are ever read. Configure only while idle, with no
// beat in flight and in_tready high (an empty walk may outlast its result beat).
// Depends on rfl_pkg and rfl_node_ram.
module run_free_list_slot_allocator_top
  import rfl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [1:0] op, [11:2] slot_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] status, [10:1] slot_out,
                                            // [32:11] byte_address
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_EMPTY
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LINK_W-1:0]       head_r, head_nxt;
  logic [OPEN_W-1:0]       open_r, open_nxt;
  logic [BLK_W-1:0]        walk_r, walk_nxt;
  logic [APB_W-1:0]        apb_cfg_r;
  logic [SIZE_W-1:0]       size_r;
  logic                    res_valid_r, res_valid_nxt;
  logic [SLOT_W-1:0]       res_slot_r, res_slot_nxt;
  logic                    res_stat_r, res_stat_nxt;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic                    ram_we, ram_re;
  logic [SLOT_W-1:0]       ram_waddr;
  node_t                   ram_wnode, ram_rnode;
  logic [NODE_W-1:0]       ram_rdata;

  logic                    accept, out_load;
  op_t                     in_op;
  logic [SLOT_W-1:0]       in_slot;
  logic [APB_W-1:0]        apb;
  logic [SLOT_W-1:0]       new_slot;
  logic [ADDR_W-1:0]       product;

  assign apb      = eff_apb(apb_cfg_r);
  assign in_op    = op_t'(in_tdata[1:0]);
  assign in_slot  = in_tdata[OP_W +: SLOT_W];
  assign out_load = res_valid_r && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) && (!res_valid_r || out_load);
  assign accept   = in_tvalid && in_tready;
  assign new_slot = {open_r[BLK_W-1:0], OFF_W'(0)};
  assign ram_re   = accept && (in_op == OP_ALLOC) && (head_r < NIL_SLOT);
  assign ram_rnode = node_t'(ram_rdata);

  rfl_node_ram #(
    .AW (SLOT_W),
    .DW (NODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wnode),
    .re    (ram_re),
    .raddr (head_r[SLOT_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    open_nxt      = open_r;
    walk_nxt      = walk_r;
    res_valid_nxt = res_valid_r && !out_load;
    res_slot_nxt  = res_slot_r;
    res_stat_nxt  = res_stat_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r[SLOT_W-1:0];
    ram_wnode     = '{link: head_r, len: LEN_W'(1)};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_valid_nxt = 1'b1;
          res_slot_nxt  = '0;
          res_stat_nxt  = ST_DONE;
          case (in_op)
            OP_ALLOC: begin
              if (head_r < NIL_SLOT) begin
                res_valid_nxt = 1'b0;
                state_nxt     = S_RMW;
              end else if (open_r < OPEN_W'(MAX_BLOCKS)) begin
                res_slot_nxt = new_slot;
                open_nxt     = open_r + OPEN_W'(1);
                // Slot 0 goes out now; the rest of the block becomes one run.
                if (apb > APB_W'(1)) begin
                  ram_we    = 1'b1;
                  ram_waddr = new_slot + SLOT_W'(1);
                  ram_wnode = '{link: head_r, len: LEN_W'(apb - APB_W'(1))};
                  head_nxt  = {1'b0, new_slot + SLOT_W'(1)};
                end
              end else begin
                res_stat_nxt = ST_FULL;
              end
            end
            OP_FREE: begin
              if ((OPEN_W'(in_slot[SLOT_W-1:OFF_W]) < open_r) &&
                  (APB_W'(in_slot[OFF_W-1:0]) < apb)) begin
                ram_we    = 1'b1;
                ram_waddr = in_slot;
                ram_wnode = '{link: head_r, len: LEN_W'(1)};
                head_nxt  = {1'b0, in_slot};
              end
            end
            OP_EMPTY: begin
              head_nxt = NIL_SLOT;
              walk_nxt = '0;
              if (open_r != '0) begin
                state_nxt = S_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RMW: begin
        // Head node read is back; take the top slot of the head run.
        ram_we        = 1'b1;
        ram_waddr     = head_r[SLOT_W-1:0];
        res_valid_nxt = 1'b1;
        res_stat_nxt  = ST_DONE;
        state_nxt     = S_IDLE;
        if (ram_rnode.len > LEN_W'(1)) begin
          ram_wnode    = '{link: ram_rnode.link, len: ram_rnode.len - LEN_W'(1)};
          res_slot_nxt = head_r[SLOT_W-1:0] + SLOT_W'(ram_rnode.len - LEN_W'(1));
        end else begin
          ram_wnode    = '{link: ram_rnode.link, len: '0};
          res_slot_nxt = head_r[SLOT_W-1:0];
          head_nxt     = (ram_rnode.link > NIL_SLOT) ? NIL_SLOT : ram_rnode.link;
        end
      end

      S_EMPTY: begin
        // Push one full run per open block, lowest block first.
        ram_we    = 1'b1;
        ram_waddr = {walk_r, OFF_W'(0)};
        ram_wnode = '{link: head_r, len: LEN_W'(apb)};
        head_nxt  = {1'b0, walk_r, OFF_W'(0)};
        walk_nxt  = walk_r + BLK_W'(1);
        if (OPEN_W'(walk_r) + OPEN_W'(1) == open_r) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign product = ADDR_W'(res_slot_r) * ADDR_W'(size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL_SLOT;
      open_r      <= '0;
      walk_r      <= '0;
      apb_cfg_r   <= APB_W'(32);
      size_r      <= SIZE_W'(20);
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      open_r      <= open_nxt;
      walk_r      <= walk_nxt;
      res_valid_r <= res_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_APB) apb_cfg_r <= cfg_wdata[APB_W-1:0];
        if (cfg_index == REG_ATOM_SIZE) size_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_slot_r <= res_slot_nxt;
    res_stat_r <= res_stat_nxt;
    if (out_load) begin
      out_data_r <= {(OUT_DATA_W - OUT_USED_W)'(0), product,
                     res_slot_r, res_stat_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/rfl_checker.sv
// Port-level checker for the run free list slot allocator, bound to the top level.
// Depends on rfl_pkg and run_free_list_slot_allocator_top_defines.svh.
`include "run_free_list_slot_allocator_top_defines.svh"

module rfl_checker
  import rfl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic             stat_bit;
  logic [SLOT_W-1:0] slot_f;
  logic [ADDR_W-1:0] addr_f;
  logic             stalled;
  logic             no_slot;

  assign stat_bit = out_tdata[OUT_STAT_LSB];
  assign slot_f   = out_tdata[OUT_SLOT_LSB +: SLOT_W];
  assign addr_f   = out_tdata[OUT_ADDR_LSB +: ADDR_W];
  assign stalled  = out_tvalid && !out_tready;
  assign no_slot  = (slot_f == '0) && (addr_f == '0);

  `RFL_ASSERT_NEXT(a_out_hold, stalled, out_tvalid, "result beat dropped while stalled")
  `RFL_ASSERT_NEXT(a_out_stable, stalled, $stable(out_tdata), "stalled result beat changed")
  `RFL_ASSERT_NOW(a_fail_no_slot, out_tvalid && stat_bit, no_slot, "failed allocation has a slot")
  `RFL_ASSERT_NOW(a_zero_addr, out_tvalid && slot_f == '0, addr_f == '0, "address without a slot")

endmodule

bind run_free_list_slot_allocator_top rfl_checker u_rfl_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the run free list slot allocator: directed beats, then random phases.
// An in-bench allocator model predicts every result beat. Depends on rfl_pkg and the top level.
module tb;
  import rfl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN    = 2'd3;
  localparam int              DRAIN_CYCLES  = 40;
  localparam int              NUM_PHASES    = 8;
  localparam int              PHASE_BEATS   = 235;

  typedef struct packed {
    logic              st;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  class slot_alloc_scoreboard;
    logic [APB_W-1:0]  apb_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] link_tbl [TABLE_DEPTH];
    logic [LEN_W-1:0]  len_tbl [TABLE_DEPTH];
    int unsigned       opened;
    alloc_result_t     due [$];
    int unsigned       errors;

    function new();
      apb_reg  = APB_W'(32);
      size_reg = SIZE_W'(20);
      head     = NIL_SLOT;
      opened   = 0;
      errors   = 0;
      foreach (link_tbl[i]) begin
        link_tbl[i] = '0;
        len_tbl[i]  = '0;
      end
    endfunction

    function void write_reg(input logic idx, input logic [SIZE_W-1:0] value);
      if (idx == REG_APB) apb_reg = value[APB_W-1:0];
      else size_reg = value;
    endfunction

    function void push_run(input int unsigned slot, input int unsigned len);
      if (slot >= TABLE_DEPTH) return;
      link_tbl[slot] = head;
      len_tbl[slot]  = LEN_W'(len);
      head           = LINK_W'(slot);
    endfunction

    // Advances the allocator by one request and queues the result it must give.
    function alloc_result_t note_request(input logic [OP_W-1:0] op,
                                         input logic [SLOT_W-1:0] slot_in);
      alloc_result_t r;
      int unsigned   apb, slot, h, n, b;
      apb  = apb_reg;
      if (apb == 0) apb = 1;
      if (apb > SLOTS_PER_BLOCK_MAX) apb = SLOTS_PER_BLOCK_MAX;
      slot = 0;
      r.st = ST_DONE;
      if (op == OP_ALLOC) begin
        if (head < TABLE_DEPTH) begin
          h = head;
          n = len_tbl[h];
          if (n > 1) begin
            n = n - 1;
            len_tbl[h] = LEN_W'(n);
            slot = h + n;
          end else begin
            len_tbl[h] = '0;
            slot = h;
            head = link_tbl[h];
            if (head > NIL_SLOT) head = NIL_SLOT;
          end
        end else if (opened < MAX_BLOCKS) begin
          slot   = opened * SLOTS_PER_BLOCK_MAX;
          opened = opened + 1;
          if (apb > 1) push_run(slot + 1, apb - 1);
        end else begin
          r.st = ST_FULL;
        end
      end else if (op == OP_FREE) begin
        if (slot_in / SLOTS_PER_BLOCK_MAX < opened && slot_in % SLOTS_PER_BLOCK_MAX < apb)
          push_run(slot_in, 1);
      end else if (op == OP_EMPTY) begin
        head = NIL_SLOT;
        for (b = 0; b < opened; b++) push_run(b * SLOTS_PER_BLOCK_MAX, apb);
      end
      r.slot = SLOT_W'(slot);
      r.addr = ADDR_W'(r.slot) * ADDR_W'(size_reg);
      due.push_back(r);
      return r;
    endfunction

    function void report(input string what);
      errors++;
      $display("ERROR @%0t: %s", $time, what);
    endfunction

    function void check_result(input logic [OUT_DATA_W-1:0] beat);
      alloc_result_t exp;
      logic              got_st;
      logic [SLOT_W-1:0] got_slot;
      logic [ADDR_W-1:0] got_addr;
      got_st   = beat[OUT_STAT_LSB];
      got_slot = beat[OUT_SLOT_LSB +: SLOT_W];
      got_addr = beat[OUT_ADDR_LSB +: ADDR_W];
      if (due.size() == 0) begin
        report($sformatf("result beat %h with no request outstanding", beat));
        return;
      end
      exp = due.pop_front();
      if (got_st !== exp.st)
        report($sformatf("status %b, expected %b", got_st, exp.st));
      if (got_slot !== exp.slot)
        report($sformatf("slot_out %0d, expected %0d", got_slot, exp.slot));
      if (got_addr !== exp.addr)
        report($sformatf("byte_address %0d, expected %0d", got_addr, exp.addr));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic                  cfg_index;
  logic [SIZE_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [1:0] op, [11:2] slot_in
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] status, [10:1] slot_out, [32:11] byte_address

  slot_alloc_scoreboard sb;
  int unsigned          live_slots [$];
  int unsigned          burst_left;

  run_free_list_slot_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: segments of random length, each with its own stall pattern.
  initial begin : result_sink
    int unsigned seg_left, mode;
    out_tready = 1'b0;
    seg_left   = 0;
    mode       = 0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 150);
      end
      seg_left--;
      case (mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 3) != 0);
        2: out_tready = ($urandom_range(0, 1) == 0);
        default: out_tready = (seg_left % 6 == 0);
      endcase
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot_in);
    alloc_result_t exp;
    in_tdata  = IN_DATA_W'({slot_in, op});
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    exp = sb.note_request(op, slot_in);
    if (op == OP_ALLOC && exp.st == ST_DONE) live_slots.push_back(exp.slot);
    else if (op == OP_EMPTY) live_slots.delete();
    @(negedge clk);
    // A following beat raises valid again in this same step, so it only drops on a gap.
    in_tvalid = 1'b0;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 10)) @(negedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_random(input int unsigned free_pct);
    int unsigned       pick, idx;
    logic [SLOT_W-1:0] slot;
    slot = SLOT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      send_beat(OP_UNKNOWN, slot);
    end else if (pick < 5) begin
      send_beat(OP_EMPTY, slot);
    end else if (pick < 5 + free_pct) begin
      if (live_slots.size() > 0 && $urandom_range(0, 9) < 8) begin
        idx  = $urandom_range(0, live_slots.size() - 1);
        slot = SLOT_W'(live_slots[idx]);
        // Now and then the slot stays in the pool, so it gets freed twice.
        if ($urandom_range(0, 15) != 0) live_slots.delete(idx);
      end
      send_beat(OP_FREE, slot);
    end else begin
      send_beat(OP_ALLOC, slot);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] value);
    cfg_index = idx;
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, value);
  endtask

  // An empty walk can still be running after its result beat has gone out.
  task automatic wait_results_drained();
    while (sb.due.size() != 0 || !in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned phase_apb [NUM_PHASES];
    int unsigned phase_size [NUM_PHASES];
    sb         = new();
    burst_left = 0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_APB;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    phase_apb  = '{1, 0, 3, 64, 127, 17, 5, 2};
    phase_size = '{0, 8191, 1, 4096, 20, 813, 8191, 257};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: opening, run use, frees good and bad, double free, empty.
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_ALLOC, 10'd1023);
    send_beat(OP_FREE, 10'd31);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_FREE, 10'd1023);
    send_beat(OP_FREE, 10'd40);
    send_beat(OP_UNKNOWN, 10'd1023);
    send_beat(OP_UNKNOWN, 10'd0);
    send_beat(OP_FREE, 10'd0);
    send_beat(OP_FREE, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_EMPTY, 10'd1023);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_FREE, 10'd5);
    send_beat(OP_ALLOC, 10'd0);
    wait_results_drained();

    // Single-slot blocks with a zero atom size.
    write_reg(REG_APB, 13'd1);
    write_reg(REG_ATOM_SIZE, 13'd0);
    send_beat(OP_EMPTY, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    wait_results_drained();

    // Largest block and atom size.
    write_reg(REG_APB, 13'd64);
    write_reg(REG_ATOM_SIZE, 13'd8191);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_ALLOC, 10'd0);
    send_beat(OP_FREE, 10'd255);
    wait_results_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_APB, SIZE_W'(phase_apb[p]));
      write_reg(REG_ATOM_SIZE, SIZE_W'(phase_size[p]));
      // Alloc-heavy phases alternate with balanced ones so the list both runs dry and refills.
      for (int i = 0; i < PHASE_BEATS; i++) send_random((p % 2 == 0) ? 20 : 45);
      wait_results_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
